// File: src/psd_pkg.sv
// Shared constants and types of the descending priority sorter.
package psd_pkg;

   localparam int ENTRIES     = 16;
   localparam int CNT_W       = $clog2(ENTRIES);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic              [7:0] symbol;
      logic signed       [7:0] key;
      logic                    close;
   } entry_type;

   typedef struct packed {
      logic push;
      logic full;
   } queue_ctl_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } back_state_type;

endpackage

// File: src/psd_if.sv
// Request and response channel interfaces of the descending priority sorter.
interface psd_req_if;
   logic              valid;
   logic              ready;
   logic        [7:0] symbol;
   logic signed [7:0] priority_req;
   logic              last;

   modport source (output valid, symbol, priority_req, last, input ready);
   modport sink   (input valid, symbol, priority_req, last, output ready);
endinterface

interface psd_rsp_if;
   logic              valid;
   logic              ready;
   logic        [7:0] symbol_out;
   logic signed [7:0] priority_out;
   logic              final_res;

   modport source (output valid, symbol_out, priority_out, final_res, input ready);
   modport sink   (input valid, symbol_out, priority_out, final_res, output ready);
endinterface

// File: src/psd_front.sv
// Front end: takes requests, counts the set and marks the request that closes it.
module psd_front (
   input  logic                    clock,
   input  logic                    reset,
   psd_req_if.sink                 req,
   output psd_pkg::queue_ctl_type  q_ctl,
   input  logic                    q_full,
   output psd_pkg::entry_type      q_data
);
   import psd_pkg::*;

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             close;
   logic             push;

   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;
   assign close     = req.last || (cnt_ff == CNT_W'(ENTRIES - 1));

   assign q_ctl.push = push;
   assign q_ctl.full = q_full;

   assign q_data.symbol = req.symbol;
   assign q_data.key    = req.priority_req;
   assign q_data.close  = close;

   always_comb begin
      cnt_in = cnt_ff;
      if (push) begin
         cnt_in = close ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: src/psd_fifo.sv
// Short queue of classified requests between front and back end.
module psd_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  psd_pkg::queue_ctl_type  q_ctl,
   input  psd_pkg::entry_type      wr_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    empty,
   output psd_pkg::entry_type      rd_data
);
   import psd_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = q_ctl.push && !q_ctl.full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/psd_back.sv
// Back end: insertion chain that keeps the set sorted, then drains it in order.
module psd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  psd_pkg::entry_type  q_data,
   output logic                q_pop,
   psd_rsp_if.source           rsp
);
   import psd_pkg::*;

   back_state_type    state_ff;
   back_state_type    state_in;

   logic signed [7:0] key_ff   [ENTRIES];
   logic signed [7:0] key_in   [ENTRIES];
   logic        [7:0] sym_ff   [ENTRIES];
   logic        [7:0] sym_in   [ENTRIES];
   logic signed [7:0] key_up   [ENTRIES];
   logic        [7:0] sym_up   [ENTRIES];
   logic signed [7:0] key_dn   [ENTRIES];
   logic        [7:0] sym_dn   [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [ENTRIES-1:0] valid_up;
   logic [ENTRIES-1:0] valid_dn;
   logic [ENTRIES-1:0] slot;
   logic [ENTRIES-1:0] slot_up;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic        [7:0] rsp_sym_ff;
   logic signed [7:0] rsp_key_ff;
   logic              rsp_final_ff;
   logic              drain;

   // A cell is open for the new pair when it is empty or holds a smaller key.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         slot[i] = !valid_ff[i] || (key_ff[i] < q_data.key);
      end
   end

   assign slot_up  = {slot[ENTRIES-2:0], 1'b0};
   assign valid_up = {valid_ff[ENTRIES-2:0], 1'b1};
   assign valid_dn = {1'b0, valid_ff[ENTRIES-1:1]};

   for (genvar g = 0; g < ENTRIES; g++) begin : g_nbr
      if (g == 0) begin : g_first
         assign key_up[g] = q_data.key;
         assign sym_up[g] = q_data.symbol;
      end else begin : g_rest
         assign key_up[g] = key_ff[g-1];
         assign sym_up[g] = sym_ff[g-1];
      end
      if (g == ENTRIES - 1) begin : g_last
         assign key_dn[g] = key_ff[g];
         assign sym_dn[g] = sym_ff[g];
      end else begin : g_inner
         assign key_dn[g] = key_ff[g+1];
         assign sym_dn[g] = sym_ff[g+1];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (!q_empty && q_data.close) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain && !valid_ff[1]) begin
               state_in = ST_FILL;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   // State outputs.
   always_comb begin
      q_pop = 1'b0;
      drain = 1'b0;
      case (state_ff)
         ST_FILL:  q_pop = !q_empty;
         ST_DRAIN: drain = !rsp_valid_ff || rsp.ready;
         default: begin
            q_pop = 1'b0;
            drain = 1'b0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i] = key_ff[i];
         sym_in[i] = sym_ff[i];
         if (q_pop) begin
            if (slot_up[i]) begin
               key_in[i] = key_up[i];
               sym_in[i] = sym_up[i];
            end else if (slot[i]) begin
               key_in[i] = q_data.key;
               sym_in[i] = q_data.symbol;
            end
         end else if (drain) begin
            key_in[i] = key_dn[i];
            sym_in[i] = sym_dn[i];
         end
      end
      if (q_pop) begin
         valid_in = valid_ff | valid_up;
      end else if (drain) begin
         valid_in = valid_dn;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (drain) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i] <= key_in[i];
         sym_ff[i] <= sym_in[i];
      end
      if (drain) begin
         rsp_sym_ff   <= sym_ff[0];
         rsp_key_ff   <= key_ff[0];
         rsp_final_ff <= !valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.symbol_out   = rsp_sym_ff;
   assign rsp.priority_out = rsp_key_ff;
   assign rsp.final_res    = rsp_final_ff;

endmodule

// File: src/priority_sort_descending.sv
// A closing request is written into the queue when accepted; the back end then pops it into
// the insertion chain, and the first sorted response is registered in the response register.
// Throughput: one request per cycle while a set is filling, with intake held once the 4-deep
// queue is full; a set of n pairs then drains one response per cycle while the receiver is ready.
// Reset clears the set counter, queue pointers, chain valid bits and response valid.
module priority_sort_descending (
   input  logic        clock,
   input  logic        reset,
   psd_req_if.sink     req_chan,
   psd_rsp_if.source   rsp_chan
);
   import psd_pkg::*;

   queue_ctl_type q_ctl;
   entry_type     q_wr_data;
   entry_type     q_rd_data;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;

   psd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_ctl  (q_ctl),
      .q_full (q_full),
      .q_data (q_wr_data)
   );

   psd_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .q_ctl   (q_ctl),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_rd_data)
   );

   psd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_rd_data),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule
